>>> design/bpt_pkg.sv
// Package with shared types and constants of the blocked point table.
package bpt_pkg;

    localparam int unsigned TIME_W  = 40;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned TTL_W   = 32;
    localparam int unsigned HOLD_W  = 32;
    localparam int unsigned DIST_W  = 21;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned ENTRY_W = 2 * COORD_W + TIME_W;

    localparam logic [1:0] REG_TTL  = 2'd0;
    localparam logic [1:0] REG_HOLD = 2'd1;
    localparam logic [1:0] REG_DIST = 2'd2;

    localparam logic [TTL_W-1:0]  TTL_RESET  = 32'd60000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd2000;
    localparam logic [DIST_W-1:0] DIST_RESET = 21'd819;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PURGE_RD,
        ST_PURGE_CHK,
        ST_DECIDE,
        ST_MERGE_RD,
        ST_MERGE_SQ,
        ST_MERGE_CHK,
        ST_APPEND,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TIME_W-1:0]         expiry;
    } t_entry;

endpackage

>>> design/blocked_point_table_ttl_merge.sv
// Top level of the blocked point table with lifetime and merging.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  input   | in        | i_in_valid/o_in_stall  | now_ms, path_blocked, x, y
//  output  | out       | o_out_valid/i_out_stall| entry fields, dropped, last
//  config  | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// Each word purges expired entries, may walk the table to merge the point or,
// when no entry is close enough, append it, and then sends every entry as a result.
// Every table access goes through the one RAM, with its registered read port.
// Reset empties the table at once through the fill count; no clearing pass.
// A stalled result holds the walk; the next word is taken once the last result
// sits in the output register.
module blocked_point_table_ttl_merge #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [bpt_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bpt_pkg::TIME_W-1:0]          i_now_ms,
    input  logic                                i_path_blocked,
    input  logic signed [bpt_pkg::COORD_W-1:0]  i_blocked_x,
    input  logic signed [bpt_pkg::COORD_W-1:0]  i_blocked_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_entry_valid,
    output logic signed [bpt_pkg::COORD_W-1:0]  o_entry_x,
    output logic signed [bpt_pkg::COORD_W-1:0]  o_entry_y,
    output logic [bpt_pkg::TIME_W-1:0]          o_entry_expiry_ms,
    output logic                                o_point_dropped,
    output logic                                o_last
);
    import bpt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RD = 1 << AW;
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic [TTL_W-1:0]  r_ttl;
    logic [HOLD_W-1:0] r_hold;
    logic [DIST_W-1:0] r_dist;

    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_keep, n_keep;
    logic [TIME_W-1:0] r_hold_start, n_hold_start;
    logic              r_hold_active, n_hold_active;
    logic              r_dropped, n_dropped;

    logic [TIME_W-1:0]         r_now;
    logic                      r_blk;
    logic signed [COORD_W-1:0] r_bx, r_by;
    logic [TIME_W-1:0]         r_exp;
    logic [2*DIST_W-1:0]       r_lim;
    logic [2*COORD_W+1:0]      r_d2;

    logic   ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry ram_wdata, ram_rdata;

    logic r_out_valid, n_out_valid;
    t_entry r_out_e, n_out_e;
    logic r_out_ev, n_out_ev, r_out_last, n_out_last;
    logic r_out_drop, n_out_drop;

    logic signed [COORD_W:0] dx, dy;
    logic [2*COORD_W+1:0] sq_x, sq_y;
    logic [TIME_W:0] exp_sum;
    logic [TIME_W-1:0] elapsed;
    logic signed [COORD_W:0] mx, my;

    bpt_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl  <= TTL_RESET;
            r_hold <= HOLD_RESET;
            r_dist <= DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TTL:  r_ttl  <= i_cfg_data[TTL_W-1:0];
                REG_HOLD: r_hold <= i_cfg_data[HOLD_W-1:0];
                REG_DIST: r_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign dx = {ram_rdata.x[COORD_W-1], ram_rdata.x} - {r_bx[COORD_W-1], r_bx};
    assign dy = {ram_rdata.y[COORD_W-1], ram_rdata.y} - {r_by[COORD_W-1], r_by};
    // The signed operands are widened to the full product width before multiplying.
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign mx = ({ram_rdata.x[COORD_W-1], ram_rdata.x} + {r_bx[COORD_W-1], r_bx}) >>> 1;
    assign my = ({ram_rdata.y[COORD_W-1], ram_rdata.y} + {r_by[COORD_W-1], r_by}) >>> 1;
    assign exp_sum = {1'b0, i_now_ms} + (TIME_W+1)'(r_ttl);
    assign elapsed = (r_now >= r_hold_start) ? r_now - r_hold_start : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_hold_start  <= '0;
            r_hold_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_hold_start  <= n_hold_start;
            r_hold_active <= n_hold_active;
            r_out_valid   <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_keep     <= n_keep;
        r_dropped  <= n_dropped;
        r_out_e    <= n_out_e;
        r_out_ev   <= n_out_ev;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_now <= i_now_ms;
            r_blk <= i_path_blocked;
            r_bx  <= i_blocked_x;
            r_by  <= i_blocked_y;
            r_exp <= exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
            r_lim <= r_dist * r_dist;
        end
        r_d2 <= sq_x + sq_y;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_keep        = r_keep;
        n_hold_start  = r_hold_start;
        n_hold_active = r_hold_active;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid;
        n_out_e       = r_out_e;
        n_out_ev      = r_out_ev;
        n_out_last    = r_out_last;
        n_out_drop    = r_out_drop;
        ram_we        = 1'b0;
        ram_waddr     = r_keep[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = r_idx[AW-1:0];
        o_in_stall    = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_idx  = '0;
                n_keep = '0;
                n_dropped = 1'b0;
                if (i_in_valid) begin
                    n_state = ST_PURGE_RD;
                end
            end
            ST_PURGE_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_keep;
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_PURGE_CHK;
                end
            end
            ST_PURGE_CHK: begin
                // Survivors are compacted downwards; keep never passes idx.
                if (ram_rdata.expiry > r_now) begin
                    ram_we = 1'b1;
                    n_keep = r_keep + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = ST_PURGE_RD;
            end
            ST_DECIDE: begin
                n_idx = '0;
                n_state = ST_OUT_RD;
                if (r_blk) begin
                    if (!r_hold_active) begin
                        n_hold_active = 1'b1;
                        n_hold_start  = r_now;
                    end
                    if ((r_hold_active ? elapsed : '0) >= TIME_W'(r_hold)) begin
                        n_hold_start = r_now;
                        n_state = ST_MERGE_RD;
                    end
                end else begin
                    n_hold_active = 1'b0;
                    n_hold_start  = '0;
                end
            end
            ST_MERGE_RD: begin
                n_state = (r_idx == r_count) ? ST_APPEND : ST_MERGE_SQ;
            end
            ST_MERGE_SQ: begin
                n_state = ST_MERGE_CHK;
            end
            ST_MERGE_CHK: begin
                if (r_d2 <= (2*COORD_W+2)'(r_lim)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata.x = mx[COORD_W-1:0];
                    ram_wdata.y = my[COORD_W-1:0];
                    ram_wdata.expiry = r_exp;
                    n_idx   = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_MERGE_RD;
                end
            end
            ST_APPEND: begin
                n_idx = '0;
                n_state = ST_OUT_RD;
                if (r_count == FULL) begin
                    n_dropped = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[AW-1:0];
                    ram_wdata.x = r_bx;
                    ram_wdata.y = r_by;
                    ram_wdata.expiry = r_exp;
                    n_count = r_count + 1'b1;
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_drop  = r_dropped;
                    if (r_count == '0) begin
                        n_out_ev   = 1'b0;
                        n_out_e    = '0;
                        n_out_last = 1'b1;
                    end else begin
                        n_out_ev   = 1'b1;
                        n_out_e    = ram_rdata;
                        n_out_last = (r_idx + 1'b1 == r_count);
                    end
                    if (n_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_entry_valid     = r_out_ev;
    assign o_entry_x         = r_out_e.x;
    assign o_entry_y         = r_out_e.y;
    assign o_entry_expiry_ms = r_out_e.expiry;
    assign o_point_dropped   = r_out_drop;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("table fill count beyond depth");
    a_keep_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keep <= r_idx || r_state == ST_IDLE || r_state == ST_OUT_RD
        || r_state == ST_OUT_WAIT || r_state == ST_OUT_HOLD || r_state == ST_DECIDE
        || r_state == ST_MERGE_RD || r_state == ST_MERGE_SQ || r_state == ST_MERGE_CHK
        || r_state == ST_APPEND) else $error("purge write overtook read");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_in_stall) else $error("word taken while busy");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_last) else $error("empty result not last");
`endif
endmodule

>>> design/bpt_ram.sv
// Generic simple dual port RAM (one write port, one read port) with registered read.
module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
